FILE: rtl/contiguous_page_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous page allocator checks.
// Both macros sample on posedge clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contiguous_page_allocator: check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contiguous_page_allocator: check failed");

`endif

FILE: rtl/cpa_pkg.sv
// ---------------------------------------------------------------------------
// cpa_pkg
// Shared types, codes and defaults of the contiguous page allocator.
// ---------------------------------------------------------------------------
package cpa_pkg;

  localparam int CPA_MAX_PAGES  = 1024;
  localparam int CPA_PAGE_BYTES = 4096;

  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W = 11;
  localparam int ADDR_W  = 32;

  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [COUNT_W-1:0] PAGES_RST = 11'd1024;
  localparam logic [COUNT_W-1:0] RSVD_RST  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_PAGES = 2'd1,
    CFG_RSVD  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_RUN = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MARK,
    ST_FREE_RD,
    ST_FREE_LEN,
    ST_FREE_WR,
    ST_RESP
  } cpa_state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [COUNT_W-1:0] num_pages;
    logic [ADDR_W-1:0]  phys_address;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] run_address;
  } rsp_t;

  // Write strobes and free-bit write data of the page map memories
  typedef struct packed {
    logic free_we;
    logic free_wbit;
    logic len_we;
  } mem_ctl_t;

endpackage

FILE: rtl/cpa_if.sv
// ---------------------------------------------------------------------------
// cpa_req_if / cpa_rsp_if
// Valid/ready channels carrying allocator requests and results.
// ---------------------------------------------------------------------------
interface cpa_req_if
  import cpa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [COUNT_W-1:0] num_pages;
  logic [ADDR_W-1:0]  phys_address;

  modport source (output valid, req_type, num_pages, phys_address, input ready);
  modport sink   (input valid, req_type, num_pages, phys_address, output ready);
endinterface

interface cpa_rsp_if
  import cpa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] run_address;

  modport source (output valid, status, run_address, input ready);
  modport sink   (input valid, status, run_address, output ready);
endinterface

FILE: rtl/cpa_page_mem.sv
// ---------------------------------------------------------------------------
// cpa_page_mem
// Page map storage: free bit and run length per page, registered read.
// ---------------------------------------------------------------------------
module cpa_page_mem
  import cpa_pkg::*;
#(
  parameter int DEPTH = CPA_MAX_PAGES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] len_wdata,
  input  logic [AW-1:0]      raddr,
  output logic               free_rd_r,
  output logic [COUNT_W-1:0] len_rd_r
);

  logic               free_mem [DEPTH];
  logic [COUNT_W-1:0] len_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.free_we) begin
      free_mem[waddr] <= ctl.free_wbit;
    end
    if (ctl.len_we) begin
      len_mem[waddr] <= len_wdata;
    end
    free_rd_r <= free_mem[raddr];
    len_rd_r  <= len_mem[raddr];
  end

endmodule

FILE: rtl/cpa_ctrl.sv
// ---------------------------------------------------------------------------
// cpa_ctrl
// Request sequencer: config registers, map sweep, first-fit scan, free walk.
// ---------------------------------------------------------------------------
module cpa_ctrl
  import cpa_pkg::*;
#(
  parameter int MAX_PAGES  = CPA_MAX_PAGES,
  parameter int PAGE_BYTES = CPA_PAGE_BYTES,
  localparam int AW = $clog2(MAX_PAGES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  output mem_ctl_t             mem_ctl,
  output logic [AW-1:0]        waddr,
  output logic [AW-1:0]        raddr,
  output logic [COUNT_W-1:0]   len_wdata,
  input  logic                 free_rd_r,
  input  logic [COUNT_W-1:0]   len_rd_r
);

  localparam int NW       = $clog2(MAX_PAGES + 1);
  localparam int PB_SHIFT = $clog2(PAGE_BYTES);

  cpa_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  base_r;
  logic [COUNT_W-1:0] pages_r;
  logic [COUNT_W-1:0] rsvd_r;
  logic [NW-1:0]      ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [NW-1:0]      pidx_r, pidx_nxt;
  logic [NW-1:0]      run_r, run_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [NW-1:0]      start_r, start_nxt;
  logic [NW-1:0]      end_r, end_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  status_t            st_r, st_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;

  logic [NW-1:0]     n_cnt;
  logic [NW-1:0]     r_cnt;
  logic [ADDR_W-1:0] free_diff;
  logic [ADDR_W-1:0] free_idx;
  logic              free_bad;
  logic              count_bad;
  logic              scan_issue;
  logic [NW-1:0]     run_inc;
  logic              scan_hit;
  logic [NW-1:0]     scan_start;
  logic              init_bit;
  logic [ADDR_W-1:0] mark_addr;
  logic              accept;

  // Managed and reserved page counts after clipping
  always_comb begin
    if (32'(pages_r) > 32'(MAX_PAGES)) begin
      n_cnt = NW'(MAX_PAGES);
    end else begin
      n_cnt = NW'(pages_r);
    end
    if (32'(rsvd_r) > 32'(n_cnt)) begin
      r_cnt = n_cnt;
    end else begin
      r_cnt = NW'(rsvd_r);
    end
  end

  assign accept     = req_valid && req_ready;
  assign free_diff  = req.phys_address - base_r;
  assign free_idx   = free_diff >> PB_SHIFT;
  assign free_bad   = (req.phys_address < base_r) || (free_idx >= 32'(n_cnt));
  assign count_bad  = (req.num_pages == '0) || (32'(req.num_pages) > 32'(n_cnt));
  assign scan_issue = ptr_r < n_cnt;
  assign run_inc    = NW'(32'(run_r) + 32'd1);
  assign scan_hit   = 32'(run_inc) == 32'(count_r);
  assign scan_start = NW'(32'(pidx_r) + 32'd1 - 32'(count_r));
  assign init_bit   = (ptr_r >= r_cnt) && (ptr_r < n_cnt);
  assign mark_addr  = base_r + (ADDR_W'(start_r) << PB_SHIFT);

  assign waddr = ptr_r[AW-1:0];
  assign raddr = ptr_r[AW-1:0];
  assign rsp.status      = st_r;
  assign rsp.run_address = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RST;
      pages_r <= PAGES_RST;
      rsvd_r  <= RSVD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  base_r  <= cfg_wdata;
        CFG_PAGES: pages_r <= cfg_wdata[COUNT_W-1:0];
        CFG_RSVD:  rsvd_r  <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    run_r   <= run_nxt;
    count_r <= count_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    rem_r   <= rem_nxt;
    st_r    <= st_nxt;
    addr_r  <= addr_nxt;
  end

  always_comb begin : next_logic
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = ptr_r;
    run_nxt   = run_r;
    count_nxt = count_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    rem_nxt   = rem_r;
    st_nxt    = st_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_CLEAR, ST_INIT: begin
        ptr_nxt = NW'(32'(ptr_r) + 32'd1);
        if (ptr_r == NW'(MAX_PAGES - 1)) begin
          ptr_nxt   = '0;
          st_nxt    = STATUS_OK;
          addr_nxt  = '0;
          state_nxt = (state_r == ST_CLEAR) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ptr_nxt  = '0;
          st_nxt   = STATUS_OK;
          addr_nxt = '0;
          unique case (req.req_type)
            REQ_INIT: state_nxt = ST_INIT;
            REQ_ALLOC: begin
              if (count_bad) begin
                st_nxt    = STATUS_NO_RUN;
                state_nxt = ST_RESP;
              end else begin
                count_nxt = req.num_pages;
                run_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            REQ_FREE: begin
              if (free_bad) begin
                st_nxt    = STATUS_RANGE;
                state_nxt = ST_RESP;
              end else begin
                ptr_nxt   = NW'(free_idx);
                state_nxt = ST_FREE_RD;
              end
            end
            REQ_NONE: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; the free bit comes back in the following cycle
        if (scan_issue) begin
          ptr_nxt  = NW'(32'(ptr_r) + 32'd1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (free_rd_r) begin
            run_nxt = run_inc;
            if (scan_hit) begin
              start_nxt = scan_start;
              end_nxt   = pidx_r;
              ptr_nxt   = scan_start;
              pend_nxt  = 1'b0;
              state_nxt = ST_MARK;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!scan_issue) begin
          st_nxt    = STATUS_NO_RUN;
          state_nxt = ST_RESP;
        end
      end
      ST_MARK: begin
        ptr_nxt = NW'(32'(ptr_r) + 32'd1);
        if (ptr_r == end_r) begin
          st_nxt    = STATUS_OK;
          addr_nxt  = mark_addr;
          state_nxt = ST_RESP;
        end
      end
      ST_FREE_RD: state_nxt = ST_FREE_LEN;
      ST_FREE_LEN: begin
        rem_nxt   = len_rd_r;
        state_nxt = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        if ((rem_r != '0) && (ptr_r < n_cnt)) begin
          ptr_nxt = NW'(32'(ptr_r) + 32'd1);
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_ready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin : out_logic
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    mem_ctl   = '0;
    len_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.free_we = 1'b1;
        mem_ctl.len_we  = 1'b1;
      end
      ST_INIT: begin
        mem_ctl.free_we   = 1'b1;
        mem_ctl.free_wbit = init_bit;
        mem_ctl.len_we    = 1'b1;
      end
      ST_IDLE: req_ready = 1'b1;
      ST_MARK: begin
        mem_ctl.free_we = 1'b1;
        mem_ctl.len_we  = ptr_r == start_r;
        len_wdata       = count_r;
      end
      ST_FREE_WR: begin
        mem_ctl.free_we   = (rem_r != '0) && (ptr_r < n_cnt);
        mem_ctl.free_wbit = 1'b1;
      end
      ST_RESP: rsp_valid = 1'b1;
      ST_SCAN, ST_FREE_RD, ST_FREE_LEN: ;
    endcase
  end

endmodule

FILE: rtl/contiguous_page_allocator.sv
// ---------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous physical page frames over a page map.
// ---------------------------------------------------------------------------
//  channel  | dir | fields                             | handshake
//  in_req   | in  | req_type, num_pages, phys_address  | valid/ready
//  out_rsp  | out | status, run_address                | valid/ready
//  cfg_*    | in  | cfg_index, cfg_wdata               | cfg_we, no wait
//
//  After reset a clearing pass writes all MAX_PAGES map entries, one per
//  cycle; no request is taken during it.
//  Init sweeps all MAX_PAGES entries before it gives the result.
//  Alloc scans free bits one page per cycle through the map read port, then
//  marks the run.
//  Free reads the stored run length, then writes one page per cycle.
//  One request is in flight at a time; a result waits in the output register
//  while the next request is accepted. PAGE_BYTES must be a power of two.
// ---------------------------------------------------------------------------
module contiguous_page_allocator
  import cpa_pkg::*;
#(
  parameter int MAX_PAGES  = CPA_MAX_PAGES,
  parameter int PAGE_BYTES = CPA_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  cpa_req_if.sink              in_req,
  cpa_rsp_if.source            out_rsp
);

  localparam int AW = $clog2(MAX_PAGES);

  req_t               req;
  rsp_t               rsp;
  logic               rsp_valid;
  logic               rsp_ready;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [COUNT_W-1:0] len_wdata;
  logic               free_rd_r;
  logic [COUNT_W-1:0] len_rd_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  assign req.req_type     = req_type_t'(in_req.req_type);
  assign req.num_pages    = in_req.num_pages;
  assign req.phys_address = in_req.phys_address;

  cpa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .raddr     (raddr),
    .len_wdata (len_wdata),
    .free_rd_r (free_rd_r),
    .len_rd_r  (len_rd_r)
  );

  cpa_page_mem #(
    .DEPTH (MAX_PAGES)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .waddr     (waddr),
    .len_wdata (len_wdata),
    .raddr     (raddr),
    .free_rd_r (free_rd_r),
    .len_rd_r  (len_rd_r)
  );

  // Output register: take a new result when empty or being drained
  assign rsp_ready = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_status_r <= rsp.status;
      out_addr_r   <= rsp.run_address;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.run_address = out_addr_r;

endmodule

FILE: rtl/cpa_checker.sv
// ---------------------------------------------------------------------------
// cpa_checker
// Port-level checks of the contiguous page allocator, bound to the top.
// ---------------------------------------------------------------------------
`include "contiguous_page_allocator_assert.svh"

module cpa_checker
  import cpa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [ADDR_W-1:0] out_run_address
);

  // Every request leaves the idle state, so no second request right after
  `CPA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A fresh result means the sequencer went back to idle
  `CPA_ASSERT_SAME(a_ready_after_result, $rose(out_valid), in_ready)

  // Only a successful allocation carries an address
  `CPA_ASSERT_SAME(a_addr_only_on_ok, out_valid && (out_run_address != '0),
                   out_status == STATUS_OK)

  // Hold a stalled result
  `CPA_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
                   out_valid && $stable(out_status) && $stable(out_run_address))

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_run_address (out_rsp.run_address)
);
